// ===== sv/cksm_pkg.sv =====
// Package for the chroma key soft mask block: widths, register indexes,
// the configuration struct and the per-item flag struct. No dependencies.
package cksm_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned DistW   = 18;
  localparam int unsigned HardW   = 9;
  localparam int unsigned SoftW   = 10;
  localparam int unsigned RootW   = 17;
  localparam int unsigned NumW    = 26;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 10;

  localparam int unsigned SqrtStages = 6;
  localparam int unsigned SqrtBits   = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HARD   = 3'd0,
    REG_SOFT   = 3'd1,
    REG_SINGLE = 3'd2,
    REG_CHROMA = 3'd3,
    REG_KEY1   = 3'd4,
    REG_KEY2   = 3'd5,
    REG_KEY3   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [HardW-1:0] hard;
    logic [SoftW-1:0] soft_eff;
    logic             single;
    logic             chroma;
    logic [ChanW-1:0] key1;
    logic [ChanW-1:0] key2;
    logic [ChanW-1:0] key3;
  } cfg_t;

  typedef struct packed {
    logic zero;
    logic full;
  } flags_t;

endpackage

// ===== sv/cksm_dist.sv =====
// Distance front end: absolute differences, squares, then sum and threshold
// compares, three register stages. Depends on cksm_pkg.
module cksm_dist (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cksm_pkg::cfg_t            cfg,
  input  logic                      in_vld,
  input  logic [cksm_pkg::ChanW-1:0] p1, p2, p3,
  input  logic [cksm_pkg::ChanW-1:0] b1, b2, b3,
  output logic                      out_vld,
  output logic [cksm_pkg::DistW-1:0] dsq,
  output cksm_pkg::flags_t          flags
);
  import cksm_pkg::*;

  logic             v1_r, v2_r, v3_r;
  logic [ChanW-1:0] a1_r, a2_r, a3_r;
  logic [ChanW-1:0] k1, k2, k3;
  logic [15:0]      s1_r, s2_r, s3_r;
  logic [17:0]      hh_r;
  logic [19:0]      ss_r;
  logic [DistW-1:0] d_nxt, d_r;
  flags_t           f_r;

  assign k1 = cfg.single ? cfg.key1 : b1;
  assign k2 = cfg.single ? cfg.key2 : b2;
  assign k3 = cfg.single ? cfg.key3 : b3;

  assign d_nxt = DistW'(s1_r) + DistW'(s2_r) + DistW'(s3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    // The luma channel drops out of the distance in chroma-only mode.
    a1_r <= cfg.chroma ? '0 : ((p1 > k1) ? p1 - k1 : k1 - p1);
    a2_r <= (p2 > k2) ? p2 - k2 : k2 - p2;
    a3_r <= (p3 > k3) ? p3 - k3 : k3 - p3;
    s1_r <= 16'(a1_r) * 16'(a1_r);
    s2_r <= 16'(a2_r) * 16'(a2_r);
    s3_r <= 16'(a3_r) * 16'(a3_r);
    hh_r <= 18'(cfg.hard) * 18'(cfg.hard);
    ss_r <= 20'(cfg.soft_eff) * 20'(cfg.soft_eff);
    d_r  <= d_nxt;
    f_r.zero <= d_nxt <= hh_r;
    f_r.full <= 20'(d_nxt) >= ss_r;
  end

  assign out_vld = v3_r;
  assign dsq     = d_r;
  assign flags   = f_r;
endmodule

// ===== sv/cksm_sqrt.sv =====
// Pipelined digit-by-digit square root of dsq * 65536, three result bits
// per stage. Depends on cksm_pkg.
module cksm_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [cksm_pkg::DistW-1:0] dsq,
  input  cksm_pkg::flags_t           in_flags,
  output logic                       out_vld,
  output logic [cksm_pkg::RootW-1:0] root,
  output cksm_pkg::flags_t           out_flags
);
  import cksm_pkg::*;

  localparam int unsigned VW = 2 * SqrtStages * SqrtBits;

  logic          vld_r  [SqrtStages];
  logic [19:0]   rem_r  [SqrtStages];
  logic [17:0]   root_r [SqrtStages];
  logic [VW-1:0] v_r    [SqrtStages];
  flags_t        flg_r  [SqrtStages];

  for (genvar s = 0; s < SqrtStages; s++) begin : g_stg
    logic          src_vld;
    logic [19:0]   src_rem, rem_nxt;
    logic [17:0]   src_root, root_nxt;
    logic [VW-1:0] src_v, v_nxt;
    flags_t        src_flg;

    if (s == 0) begin : g_first
      assign src_vld  = in_vld;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_v    = {(VW-DistW-16)'(0), dsq, 16'd0};
      assign src_flg  = in_flags;
    end else begin : g_next
      assign src_vld  = vld_r[s-1];
      assign src_rem  = rem_r[s-1];
      assign src_root = root_r[s-1];
      assign src_v    = v_r[s-1];
      assign src_flg  = flg_r[s-1];
    end

    always_comb begin
      logic [21:0] cand;
      logic [21:0] trial;
      rem_nxt  = src_rem;
      root_nxt = src_root;
      v_nxt    = src_v;
      for (int j = 0; j < SqrtBits; j++) begin
        cand  = {rem_nxt, v_nxt[VW-1 -: 2]};
        trial = {2'b00, root_nxt, 2'b01};
        if (cand >= trial) begin
          rem_nxt  = 20'(cand - trial);
          root_nxt = {root_nxt[16:0], 1'b1};
        end else begin
          rem_nxt  = cand[19:0];
          root_nxt = {root_nxt[16:0], 1'b0};
        end
        v_nxt = v_nxt << 2;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= src_vld;
      end
      rem_r[s]  <= rem_nxt;
      root_r[s] <= root_nxt;
      v_r[s]    <= v_nxt;
      flg_r[s]  <= src_flg;
    end
  end

  assign out_vld   = vld_r[SqrtStages-1];
  assign root      = root_r[SqrtStages-1][RootW-1:0];
  assign out_flags = flg_r[SqrtStages-1];
endmodule

// ===== sv/cksm_ramp.sv =====
// Ramp back end: offset and scale by 255, then an eight-bit quotient over
// two restoring division stages, then the final select. Depends on cksm_pkg.
module cksm_ramp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cksm_pkg::cfg_t             cfg,
  input  logic                       in_vld,
  input  logic [cksm_pkg::RootW-1:0] root,
  input  cksm_pkg::flags_t           in_flags,
  output logic                       out_vld,
  output logic [cksm_pkg::ChanW-1:0] mask
);
  import cksm_pkg::*;

  logic [RootW-1:0] base, diff;
  logic [NumW-1:0]  den, num_nxt, num_r;
  logic             v1_r, v2_r, v3_r;
  flags_t           f1_r, f2_r;
  logic [NumW-1:0]  rem_nxt, rem_r;
  logic [3:0]       qh_nxt, qh_r, ql_nxt;
  logic             ovf_r;
  logic [ChanW-1:0] mask_r;

  assign base = {cfg.hard, 8'd0};
  assign diff = (root > base) ? root - base : '0;
  assign num_nxt = NumW'({diff, 8'd0}) - NumW'(diff);
  assign den  = NumW'({SoftW'(cfg.soft_eff - SoftW'(cfg.hard)), 8'd0});

  always_comb begin
    rem_nxt = num_r;
    for (int k = 7; k >= 4; k--) begin
      if (rem_nxt >= (den << k)) begin
        rem_nxt = rem_nxt - (den << k);
        qh_nxt[k-4] = 1'b1;
      end else begin
        qh_nxt[k-4] = 1'b0;
      end
    end
  end

  always_comb begin
    logic [NumW-1:0] rm;
    rm = rem_r;
    for (int k = 3; k >= 0; k--) begin
      if (rm >= (den << k)) begin
        rm = rm - (den << k);
        ql_nxt[k] = 1'b1;
      end else begin
        ql_nxt[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    num_r <= num_nxt;
    f1_r  <= in_flags;
    rem_r <= rem_nxt;
    qh_r  <= qh_nxt;
    ovf_r <= {8'd0, num_r} >= {den, 8'd0};
    f2_r  <= f1_r;
    if (f2_r.zero) begin
      mask_r <= '0;
    end else if (f2_r.full || ovf_r) begin
      mask_r <= '1;
    end else begin
      mask_r <= {qh_r, ql_nxt};
    end
  end

  assign out_vld = v3_r;
  assign mask    = mask_r;
endmodule

// ===== sv/chroma_key_soft_mask.sv =====
// Top level of the chroma key soft mask: configuration registers and the
// distance, square root and ramp pipelines. Depends on cksm_pkg and the
// cksm_dist, cksm_sqrt and cksm_ramp modules.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------
//  input    | start, busy (always low) | in_pixel_c1..c3, in_backdrop_c1..c3
//  result   | out_valid strobe         | out_mask_value
//  config   | cfg_valid, cfg_ready     | cfg_index, cfg_data
//
// A new pixel is taken in every cycle; each result passes through three
// distance stages, six square-root stages of three bits each, and three
// ramp and division stages.
// The receiver cannot stall, so the pipeline always advances and busy is low.
// Reset clears the valid bits and loads the register defaults.
module chroma_key_soft_mask (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [cksm_pkg::ChanW-1:0]   in_pixel_c1,
  input  logic [cksm_pkg::ChanW-1:0]   in_pixel_c2,
  input  logic [cksm_pkg::ChanW-1:0]   in_pixel_c3,
  input  logic [cksm_pkg::ChanW-1:0]   in_backdrop_c1,
  input  logic [cksm_pkg::ChanW-1:0]   in_backdrop_c2,
  input  logic [cksm_pkg::ChanW-1:0]   in_backdrop_c3,
  output logic                         out_valid,
  output logic [cksm_pkg::ChanW-1:0]   out_mask_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cksm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [cksm_pkg::CfgDatW-1:0] cfg_data
);
  import cksm_pkg::*;

  logic [HardW-1:0] hard_r;
  logic [SoftW-1:0] soft_r;
  logic             single_r, chroma_r;
  logic [ChanW-1:0] key1_r, key2_r, key3_r;
  cfg_t             cfg;

  logic             d_vld, s_vld;
  logic [DistW-1:0] dsq;
  flags_t           d_flags, s_flags;
  logic [RootW-1:0] root;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hard_r   <= '0;
      soft_r   <= SoftW'(1);
      single_r <= 1'b1;
      chroma_r <= 1'b0;
      key1_r   <= '0;
      key2_r   <= '0;
      key3_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HARD:   hard_r   <= cfg_data[HardW-1:0];
        REG_SOFT:   soft_r   <= cfg_data;
        REG_SINGLE: single_r <= cfg_data[0];
        REG_CHROMA: chroma_r <= cfg_data[0];
        REG_KEY1:   key1_r   <= cfg_data[ChanW-1:0];
        REG_KEY2:   key2_r   <= cfg_data[ChanW-1:0];
        REG_KEY3:   key3_r   <= cfg_data[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // A soft threshold not above the hard one acts as hard plus one.
  always_comb begin
    cfg.hard     = hard_r;
    cfg.soft_eff = (soft_r <= SoftW'(hard_r)) ? SoftW'(hard_r) + SoftW'(1) : soft_r;
    cfg.single   = single_r;
    cfg.chroma   = chroma_r;
    cfg.key1     = key1_r;
    cfg.key2     = key2_r;
    cfg.key3     = key3_r;
  end

  cksm_dist u_dist (
    .clk, .rst_n, .cfg,
    .in_vld (start && !busy),
    .p1 (in_pixel_c1), .p2 (in_pixel_c2), .p3 (in_pixel_c3),
    .b1 (in_backdrop_c1), .b2 (in_backdrop_c2), .b3 (in_backdrop_c3),
    .out_vld (d_vld), .dsq, .flags (d_flags)
  );

  cksm_sqrt u_sqrt (
    .clk, .rst_n,
    .in_vld (d_vld), .dsq, .in_flags (d_flags),
    .out_vld (s_vld), .root, .out_flags (s_flags)
  );

  cksm_ramp u_ramp (
    .clk, .rst_n, .cfg,
    .in_vld (s_vld), .root, .in_flags (s_flags),
    .out_vld (out_valid), .mask (out_mask_value)
  );

`ifndef SYNTHESIS
  // Every accepted transaction yields a result.
  a_latency_fwd : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##12 out_valid) else $error("result missing");
  // No result appears without an earlier transaction.
  a_latency_bwd : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 12)) else $error("spurious result");
`endif
endmodule
